### rtl/core/dmpwm_pkg.sv
// ----------------------------------------------------------------------------
// dmpwm_pkg: shared types and constants of the dual motor PWM block
// Command codes, bridge codes, register indexes, reset values and the
// control and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package dmpwm_pkg;

  // Command bytes (ASCII).
  localparam logic [7:0] CMD_FWD   = 8'h71;  // 'q'
  localparam logic [7:0] CMD_REV   = 8'h68;  // 'h'
  localparam logic [7:0] CMD_LEFT  = 8'h7A;  // 'z'
  localparam logic [7:0] CMD_RIGHT = 8'h79;  // 'y'
  localparam logic [7:0] CMD_STOP  = 8'h74;  // 't'
  localparam logic [7:0] CMD_FAST  = 8'h39;  // '9'
  localparam logic [7:0] CMD_SLOW  = 8'h35;  // '5'

  // Bridge bit codes.
  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_REV = 2'd1;
  localparam logic [1:0] DIR_FWD = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_NUM    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_DIV    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_LEVEL   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_LEVEL   = 3'd5;

  // Reset values of the registers.
  localparam logic [7:0]  RST_PWM_PERIOD   = 8'd100;
  localparam logic [15:0] RST_WINDOW_TICKS = 16'd25000;
  localparam logic [7:0]  RST_SPEED_NUM    = 8'd30;
  localparam logic [15:0] RST_SPEED_DIV    = 16'd561;
  localparam logic [7:0]  RST_FAST_LEVEL   = 8'd90;
  localparam logic [7:0]  RST_SLOW_LEVEL   = 8'd50;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } dmpwm_state_t;

  typedef struct packed {
    logic accept;      // take the presented item this cycle
    logic div_step;    // advance the speed dividers by one bit
    logic div_finish;  // last divider step, write back the speeds
  } dmpwm_cmd_t;

  typedef struct packed {
    logic win_end;     // the presented item closes a measurement window
    logic div_last;    // the dividers are on their final bit
  } dmpwm_status_t;

endpackage

### rtl/core/dmpwm_ctrl.sv
// ----------------------------------------------------------------------------
// dmpwm_ctrl: handshake and sequencing controller
// Accepts ticks, owns the result valid flag and runs the divider phase that
// follows a tick which closes a measurement window.
// ----------------------------------------------------------------------------
module dmpwm_ctrl
  import dmpwm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dmpwm_status_t status,
  output dmpwm_cmd_t    cmd
);

  dmpwm_state_t state, state_next;
  logic         out_valid_next;
  logic         slot_free;
  logic         accept;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && status.win_end) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept     = accept;
    cmd.div_step   = (state == ST_DIV);
    cmd.div_finish = (state == ST_DIV) && status.div_last;
    if (accept) begin
      // A window tick holds its result back until the speeds are ready.
      out_valid_next = !status.win_end;
    end else if (cmd.div_finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/core/dmpwm_datapath.sv
// ----------------------------------------------------------------------------
// dmpwm_datapath: registers, counters, PWM compare and speed dividers
// Holds the configuration, the per-tick state and two bit-serial restoring
// dividers that turn the scaled pulse counts into speeds.
// ----------------------------------------------------------------------------
module dmpwm_datapath
  import dmpwm_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  dmpwm_cmd_t             cmd,
  output dmpwm_status_t          status,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pulse_a,
  input  logic                   pulse_b,
  input  logic                   cmd_valid,
  input  logic [7:0]             cmd_byte,
  output logic                   pwm_left,
  output logic                   pwm_right,
  output logic [1:0]             dir_left,
  output logic [1:0]             dir_right,
  output logic [15:0]            speed_left,
  output logic [15:0]            speed_right,
  output logic                   speed_update
);

  localparam int PW = COUNT_WIDTH + 8;   // width of count times numerator
  localparam int BW = $clog2(PW);

  // Configuration.
  logic [7:0]  pwm_period;
  logic [15:0] window_ticks;
  logic [7:0]  speed_numerator;
  logic [15:0] speed_divisor;
  logic [7:0]  fast_level;
  logic [7:0]  slow_level;

  // Tick state.
  logic [7:0]             tick_count;
  logic [15:0]            window_count;
  logic [COUNT_WIDTH-1:0] pulses_left, pulses_right;
  logic [7:0]             speed_level, duty_left, duty_right;

  // Divider state.
  logic [PW-1:0] quo_left, quo_right;
  logic [16:0]   rem_left, rem_right;
  logic [BW-1:0] bit_count;

  // Next values.
  logic [7:0]             speed_level_next, duty_left_next, duty_right_next;
  logic [1:0]             dir_left_next, dir_right_next;
  logic [8:0]             tick_inc;
  logic [16:0]            window_inc;
  logic [COUNT_WIDTH-1:0] pulses_left_next, pulses_right_next;
  logic [PW-1:0]          prod_left, prod_right;
  logic [16:0]            divisor_eff;
  logic [PW+16:0]         step_left, step_right;
  logic [PW-1:0]          quo_left_next, quo_right_next;

  function automatic logic [PW+16:0] div_bit(input logic [16:0]   rem,
                                              input logic [PW-1:0] quo,
                                              input logic [16:0]   dvs);
    logic [16:0] shifted;
    shifted = {rem[15:0], quo[PW-1]};
    if (shifted >= dvs) begin
      div_bit = {shifted - dvs, quo[PW-2:0], 1'b1};
    end else begin
      div_bit = {shifted, quo[PW-2:0], 1'b0};
    end
  endfunction

  function automatic logic [15:0] sat16(input logic [PW-1:0] q);
    sat16 = (q > PW'(16'hFFFF)) ? 16'hFFFF : q[15:0];
  endfunction

  // Command decode; direction commands use the level held before this tick.
  always_comb begin
    logic       drive;
    logic [1:0] dl, dr;
    drive            = 1'b0;
    dl               = DIR_OFF;
    dr               = DIR_OFF;
    speed_level_next = speed_level;
    duty_left_next   = duty_left;
    duty_right_next  = duty_right;
    dir_left_next    = dir_left;
    dir_right_next   = dir_right;
    if (cmd_valid) begin
      case (cmd_byte)
        CMD_FWD:   begin drive = 1'b1; dl = DIR_FWD; dr = DIR_FWD; end
        CMD_REV:   begin drive = 1'b1; dl = DIR_REV; dr = DIR_REV; end
        CMD_LEFT:  begin drive = 1'b1; dl = DIR_REV; dr = DIR_FWD; end
        CMD_RIGHT: begin drive = 1'b1; dl = DIR_FWD; dr = DIR_REV; end
        CMD_STOP: begin
          dir_left_next   = DIR_OFF;
          dir_right_next  = DIR_OFF;
          duty_left_next  = 8'd0;
          duty_right_next = 8'd0;
        end
        CMD_FAST: speed_level_next = fast_level;
        CMD_SLOW: speed_level_next = slow_level;
        default: ;
      endcase
    end
    if (drive) begin
      dir_left_next   = (speed_level == 8'd0) ? DIR_OFF : dl;
      dir_right_next  = (speed_level == 8'd0) ? DIR_OFF : dr;
      duty_left_next  = speed_level;
      duty_right_next = speed_level;
    end
  end

  assign tick_inc       = {1'b0, tick_count} + 9'd1;
  assign window_inc     = {1'b0, window_count} + 17'd1;
  assign status.win_end = window_inc >= {1'b0, window_ticks};
  assign status.div_last = (bit_count == '0);

  assign pulses_left_next  = pulses_left + COUNT_WIDTH'(pulse_a && (pulses_left != '1));
  assign pulses_right_next = pulses_right + COUNT_WIDTH'(pulse_b && (pulses_right != '1));

  assign prod_left  = PW'(pulses_left_next) * PW'(speed_numerator);
  assign prod_right = PW'(pulses_right_next) * PW'(speed_numerator);

  assign divisor_eff = {1'b0, (speed_divisor == 16'd0) ? 16'd1 : speed_divisor};
  assign step_left   = div_bit(rem_left, quo_left, divisor_eff);
  assign step_right  = div_bit(rem_right, quo_right, divisor_eff);
  assign quo_left_next  = step_left[PW-1:0];
  assign quo_right_next = step_right[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period      <= RST_PWM_PERIOD;
      window_ticks    <= RST_WINDOW_TICKS;
      speed_numerator <= RST_SPEED_NUM;
      speed_divisor   <= RST_SPEED_DIV;
      fast_level      <= RST_FAST_LEVEL;
      slow_level      <= RST_SLOW_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PWM_PERIOD:   pwm_period      <= cfg_data[7:0];
        REG_WINDOW_TICKS: window_ticks    <= cfg_data;
        REG_SPEED_NUM:    speed_numerator <= cfg_data[7:0];
        REG_SPEED_DIV:    speed_divisor   <= cfg_data;
        REG_FAST_LEVEL:   fast_level      <= cfg_data[7:0];
        REG_SLOW_LEVEL:   slow_level      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= 8'd0;
      window_count <= 16'd0;
      pulses_left  <= '0;
      pulses_right <= '0;
      speed_level  <= RST_SLOW_LEVEL;
      duty_left    <= 8'd0;
      duty_right   <= 8'd0;
      dir_left     <= DIR_OFF;
      dir_right    <= DIR_OFF;
      speed_left   <= 16'd0;
      speed_right  <= 16'd0;
    end else begin
      if (cmd.accept) begin
        speed_level  <= speed_level_next;
        duty_left    <= duty_left_next;
        duty_right   <= duty_right_next;
        dir_left     <= dir_left_next;
        dir_right    <= dir_right_next;
        tick_count   <= (tick_inc >= {1'b0, pwm_period}) ? 8'd0 : tick_inc[7:0];
        if (status.win_end) begin
          window_count <= 16'd0;
          pulses_left  <= '0;
          pulses_right <= '0;
        end else begin
          window_count <= window_inc[15:0];
          pulses_left  <= pulses_left_next;
          pulses_right <= pulses_right_next;
        end
      end
      if (cmd.div_finish) begin
        speed_left  <= sat16(quo_left_next);
        speed_right <= sat16(quo_right_next);
      end
    end
  end

  // Result payload and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pwm_left     <= tick_count < duty_left_next;
      pwm_right    <= tick_count < duty_right_next;
      speed_update <= status.win_end;
      quo_left     <= prod_left;
      quo_right    <= prod_right;
      rem_left     <= 17'd0;
      rem_right    <= 17'd0;
      bit_count    <= BW'(PW - 1);
    end else if (cmd.div_step) begin
      quo_left  <= quo_left_next;
      quo_right <= quo_right_next;
      rem_left  <= step_left[PW+16:PW];
      rem_right <= step_right[PW+16:PW];
      bit_count <= bit_count - BW'(1);
    end
  end

endmodule

### rtl/core/dual_motor_pwm_with_encoder_speed.sv
// ----------------------------------------------------------------------------
// dual_motor_pwm_with_encoder_speed: two H-bridge PWM channels with speed
// Drives two motor bridges from command bytes and measures encoder speed.
// ----------------------------------------------------------------------------
// Usage. Every input item is one timer tick carrying the encoder pulses of
// both motors and an optional command byte. Each accepted item yields exactly
// one result item: the PWM levels and bridge bits for that tick, the latest
// speeds and a flag that marks a fresh speed measurement.
// Handshake. An ordinary tick shows its result in the cycle after it is
// accepted, and a new tick is taken every cycle while the receiver keeps up.
// A tick that closes a measurement window starts two bit-serial restoring
// dividers, one quotient bit per cycle over COUNT_WIDTH + 8 bits, and no
// item is taken until its result appears.
// The result sits in an output register, so a new tick is taken in the same
// cycle the waiting result is collected. When the receiver stalls, the result
// holds and in_ready stays low until it is taken.
// Reset (synchronous, active high) loads the register defaults, stops both
// bridges and clears counters and speeds. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once; indexes past the last
// register are ignored.
// ----------------------------------------------------------------------------
module dual_motor_pwm_with_encoder_speed
  import dmpwm_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   pulse_a,
  input  logic                   pulse_b,
  input  logic                   cmd_valid,
  input  logic [7:0]             cmd_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   pwm_left,
  output logic                   pwm_right,
  output logic [1:0]             dir_left,
  output logic [1:0]             dir_right,
  output logic [15:0]            speed_left,
  output logic [15:0]            speed_right,
  output logic                   speed_update
);

  dmpwm_cmd_t    cmd;
  dmpwm_status_t status;

  // The controller paces the handshakes and the divider phase.
  dmpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds all state; the bridge bits and speeds are its state
  // registers, which change only when a new result is being produced.
  dmpwm_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pulse_a      (pulse_a),
    .pulse_b      (pulse_b),
    .cmd_valid    (cmd_valid),
    .cmd_byte     (cmd_byte),
    .pwm_left     (pwm_left),
    .pwm_right    (pwm_right),
    .dir_left     (dir_left),
    .dir_right    (dir_right),
    .speed_left   (speed_left),
    .speed_right  (speed_right),
    .speed_update (speed_update)
  );

endmodule

### rtl/core/dmpwm_checker.sv
// ----------------------------------------------------------------------------
// dmpwm_checker: port-level checks of the dual motor PWM block
// Watches the top-level ports and flags ordering slips of the results.
// ----------------------------------------------------------------------------
module dmpwm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  dir_left,
  input logic [1:0]  dir_right,
  input logic [15:0] speed_left,
  input logic [15:0] speed_right,
  input logic        speed_update
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // No item is taken while a result waits and is not collected.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item accepted over a waiting result");

  // Speeds move only together with a result that reports an update.
  assert property (@(posedge clk) disable iff (rst)
    !$stable(speed_left) || !$stable(speed_right) |-> out_valid && speed_update)
    else $error("speed changed without an update result");

  // Bridge bits move only right after an item is accepted.
  assert property (@(posedge clk) disable iff (rst)
    !$stable(dir_left) || !$stable(dir_right) |-> $past(in_valid && in_ready))
    else $error("bridge bits changed without an item");

endmodule

bind dual_motor_pwm_with_encoder_speed dmpwm_checker u_dmpwm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .dir_left     (dir_left),
  .dir_right    (dir_right),
  .speed_left   (speed_left),
  .speed_right  (speed_right),
  .speed_update (speed_update)
);

### dv/dual_motor_pwm_with_encoder_speed_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_motor_pwm_with_encoder_speed_tb: self-checking bench of the motor block
// Feeds timer ticks with encoder pulses and command bytes through the input
// handshake. A cycle-free copy of the PWM, bridge and speed logic predicts
// every result, and the monitor checks each result field by field. Register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module dual_motor_pwm_with_encoder_speed_tb;
  import dmpwm_pkg::*;

  localparam int COUNT_W       = 16;
  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int TARGET_TICKS  = 1850;
  // A tick that closes a window keeps the block busy while the dividers run.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = COUNT_W + 20;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_PHASE    = 4;
  localparam int MAX_PRINTS    = 40;
  localparam int LIMIT_NS      = 30_000_000;

  // Indexes past the last register; the block must ignore writes to them.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  // Command bytes that decode to nothing.
  localparam logic [7:0] UNKNOWN_LOW  = 8'h00;
  localparam logic [7:0] UNKNOWN_HIGH = 8'hFF;

  // One timer tick as it is offered to the block.
  typedef struct packed {
    logic       pulse_a;
    logic       pulse_b;
    logic       cmd_valid;
    logic [7:0] cmd_byte;
  } tick_t;

  // What the block reports for one tick.
  typedef struct packed {
    logic        pwm_l;
    logic        pwm_r;
    logic [1:0]  dir_l;
    logic [1:0]  dir_r;
    logic [15:0] spd_l;
    logic [15:0] spd_r;
    logic        upd;
  } motor_result_t;

  // Every input is known from time zero; reset is held from the start.
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic                   pulse_a   = 1'b0;
  logic                   pulse_b   = 1'b0;
  logic                   cmd_valid = 1'b0;
  logic [7:0]             cmd_byte  = 8'd0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   pwm_left;
  logic                   pwm_right;
  logic [1:0]             dir_left;
  logic [1:0]             dir_right;
  logic [15:0]            speed_left;
  logic [15:0]            speed_right;
  logic                   speed_update;

  dual_motor_pwm_with_encoder_speed #(
    .COUNT_WIDTH(COUNT_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pulse_a     (pulse_a),
    .pulse_b     (pulse_b),
    .cmd_valid   (cmd_valid),
    .cmd_byte    (cmd_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pwm_left    (pwm_left),
    .pwm_right   (pwm_right),
    .dir_left    (dir_left),
    .dir_right   (dir_right),
    .speed_left  (speed_left),
    .speed_right (speed_right),
    .speed_update(speed_update)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predicted block: register copies and state, advanced once per taken tick.
  // --------------------------------------------------------------------------
  logic [7:0]         reg_period;
  logic [15:0]        reg_window;
  logic [7:0]         reg_num;
  logic [15:0]        reg_div;
  logic [7:0]         reg_fast;
  logic [7:0]         reg_slow;

  logic [7:0]         tick_cnt;
  logic [15:0]        win_cnt;
  logic [COUNT_W-1:0] cnt_left;
  logic [COUNT_W-1:0] cnt_right;
  logic [7:0]         level;
  logic [7:0]         duty_l;
  logic [7:0]         duty_r;
  logic [1:0]         bridge_l;
  logic [1:0]         bridge_r;
  logic [15:0]        spd_l;
  logic [15:0]        spd_r;

  tick_t         pending_ticks[$];
  motor_result_t expected_results[$];

  int  errors        = 0;
  int  ticks_queued  = 0;
  int  ticks_taken   = 0;
  int  results_seen  = 0;
  int  updates_seen  = 0;
  int  settings_used = 0;
  bit  offering      = 1'b0;
  bit  long_hold_req = 1'b0;

  task automatic predictor_reset();
    reg_period = RST_PWM_PERIOD;
    reg_window = RST_WINDOW_TICKS;
    reg_num    = RST_SPEED_NUM;
    reg_div    = RST_SPEED_DIV;
    reg_fast   = RST_FAST_LEVEL;
    reg_slow   = RST_SLOW_LEVEL;
    tick_cnt   = '0;
    win_cnt    = '0;
    cnt_left   = '0;
    cnt_right  = '0;
    level      = RST_SLOW_LEVEL;
    duty_l     = '0;
    duty_r     = '0;
    bridge_l   = DIR_OFF;
    bridge_r   = DIR_OFF;
    spd_l      = '0;
    spd_r      = '0;
  endtask

  // The 8-bit register copies take only the low bits of the write data, and
  // writes to the spare indexes change nothing.
  function automatic void store_reg(logic [CFG_INDEX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PWM_PERIOD:   reg_period = data[7:0];
      REG_WINDOW_TICKS: reg_window = data;
      REG_SPEED_NUM:    reg_num    = data[7:0];
      REG_SPEED_DIV:    reg_div    = data;
      REG_FAST_LEVEL:   reg_fast   = data[7:0];
      REG_SLOW_LEVEL:   reg_slow   = data[7:0];
      default: ;
    endcase
  endfunction

  // A direction command loads the current level into both duties. A level
  // of zero leaves the bridges off whatever direction was asked for.
  function automatic void steer(logic [1:0] dl, logic [1:0] dr);
    if (level == 8'd0) begin
      bridge_l = DIR_OFF;
      bridge_r = DIR_OFF;
    end else begin
      bridge_l = dl;
      bridge_r = dr;
    end
    duty_l = level;
    duty_r = level;
  endfunction

  // Count times numerator over divisor, with a zero divisor taken as one
  // and the quotient clipped to 16 bits.
  function automatic logic [15:0] pulses_to_speed(logic [COUNT_W-1:0] n);
    logic [COUNT_W+7:0] scaled;
    logic [COUNT_W+7:0] quot;
    logic [15:0]        d;
    d      = (reg_div == 16'd0) ? 16'd1 : reg_div;
    scaled = (COUNT_W+8)'(n) * (COUNT_W+8)'(reg_num);
    quot   = scaled / d;
    return (quot > 65535) ? 16'hFFFF : quot[15:0];
  endfunction

  // One tick: command first, then PWM from the old tick count, then the
  // counters advance and the window is closed if it is due.
  function automatic motor_result_t advance_tick(tick_t t);
    motor_result_t r;
    if (t.cmd_valid) begin
      case (t.cmd_byte)
        CMD_FWD:   steer(DIR_FWD, DIR_FWD);
        CMD_REV:   steer(DIR_REV, DIR_REV);
        CMD_LEFT:  steer(DIR_REV, DIR_FWD);
        CMD_RIGHT: steer(DIR_FWD, DIR_REV);
        CMD_STOP: begin
          bridge_l = DIR_OFF;
          bridge_r = DIR_OFF;
          duty_l   = '0;
          duty_r   = '0;
        end
        CMD_FAST:  level = reg_fast;
        CMD_SLOW:  level = reg_slow;
        default: ;
      endcase
    end
    r.pwm_l = (tick_cnt < duty_l);
    r.pwm_r = (tick_cnt < duty_r);
    // A period of zero wraps like a period of one.
    if ((tick_cnt + 9'd1) >= reg_period) tick_cnt = '0;
    else tick_cnt = tick_cnt + 8'd1;
    if (t.pulse_a && (cnt_left != '1)) cnt_left = cnt_left + 1'b1;
    if (t.pulse_b && (cnt_right != '1)) cnt_right = cnt_right + 1'b1;
    r.upd = 1'b0;
    if ((win_cnt + 17'd1) >= reg_window) begin
      win_cnt   = '0;
      spd_l     = pulses_to_speed(cnt_left);
      spd_r     = pulses_to_speed(cnt_right);
      cnt_left  = '0;
      cnt_right = '0;
      r.upd     = 1'b1;
    end else begin
      win_cnt = win_cnt + 16'd1;
    end
    r.dir_l = bridge_l;
    r.dir_r = bridge_r;
    r.spd_l = spd_l;
    r.spd_r = spd_r;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idle gaps shared by both sides: mostly none or short, now and then a long
  // one, and from time to time a calm stretch with no gaps at all.
  // --------------------------------------------------------------------------
  function automatic int draw_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH result %0d: %s is %0d, predicted %0d",
               results_seen, what, got, want);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the queued ticks one by one. A tick is predicted at the
  // edge where it is taken, so the expectation order is the acceptance order.
  // --------------------------------------------------------------------------
  tick_t shown_tick;
  int    tx_wait = 0;
  int    tx_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      tx_wait  = 0;
    end else begin
      if (offering && in_ready) begin
        expected_results.push_back(advance_tick(shown_tick));
        ticks_taken++;
        offering = 1'b0;
        tx_wait  = draw_gap(tx_calm);
      end
      // While a tick is still waiting, valid and payload are left alone.
      if (!offering) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          shown_tick = pending_ticks.pop_front();
          offering   = 1'b1;
          in_valid  <= 1'b1;
          pulse_a   <= shown_tick.pulse_a;
          pulse_b   <= shown_tick.pulse_b;
          cmd_valid <= shown_tick.cmd_valid;
          cmd_byte  <= shown_tick.cmd_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: collects results, checks them against the oldest prediction and
  // stalls the block at random. On request it holds off for a long stretch
  // so that the output register fills and the block refuses new ticks.
  // --------------------------------------------------------------------------
  int rx_wait = 0;
  int rx_calm = 0;

  always @(posedge clk) begin : monitor
    motor_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no tick pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (pwm_left !== want.pwm_l) report_mismatch("pwm_left", pwm_left, want.pwm_l);
          if (pwm_right !== want.pwm_r) report_mismatch("pwm_right", pwm_right, want.pwm_r);
          if (dir_left !== want.dir_l) report_mismatch("dir_left", dir_left, want.dir_l);
          if (dir_right !== want.dir_r) report_mismatch("dir_right", dir_right, want.dir_r);
          if (speed_left !== want.spd_l)
            report_mismatch("speed_left", speed_left, want.spd_l);
          if (speed_right !== want.spd_r)
            report_mismatch("speed_right", speed_right, want.spd_r);
          if (speed_update !== want.upd)
            report_mismatch("speed_update", speed_update, want.upd);
          if (want.upd) updates_seen++;
        end
        rx_wait = draw_gap(rx_calm);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_wait       = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_tick(input tick_t t);
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  function automatic tick_t mk_tick(logic pa, logic pb, logic cv, logic [7:0] cb);
    tick_t t;
    t.pulse_a   = pa;
    t.pulse_b   = pb;
    t.cmd_valid = cv;
    t.cmd_byte  = cb;
    return t;
  endfunction

  function automatic logic [7:0] known_cmd(int sel);
    case (sel)
      0:       return CMD_FWD;
      1:       return CMD_REV;
      2:       return CMD_LEFT;
      3:       return CMD_RIGHT;
      4:       return CMD_STOP;
      5:       return CMD_FAST;
      default: return CMD_SLOW;
    endcase
  endfunction

  // Mostly real commands when a command is present, with some stray bytes;
  // ticks without a command carry a random byte that must be ignored.
  function automatic tick_t random_tick(int pct_a, int pct_b, int pct_cmd);
    tick_t t;
    t.pulse_a   = ($urandom_range(0, 99) < pct_a);
    t.pulse_b   = ($urandom_range(0, 99) < pct_b);
    t.cmd_valid = ($urandom_range(0, 99) < pct_cmd);
    if (t.cmd_valid && ($urandom_range(0, 99) < 85))
      t.cmd_byte = known_cmd($urandom_range(0, 6));
    else
      t.cmd_byte = 8'($urandom());
    return t;
  endfunction

  function automatic int pick_density();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 4) return 100;
    return $urandom_range(0, 100);
  endfunction

  function automatic logic [7:0] pick_byte_setting();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    store_reg(idx, data);
  endtask

  // The 8-bit registers get random upper data bits, which must be dropped.
  task automatic program_registers(input logic [7:0] period, input logic [15:0] window,
                                   input logic [7:0] num, input logic [15:0] div,
                                   input logic [7:0] fast, input logic [7:0] slow);
    write_reg(REG_PWM_PERIOD, {8'($urandom()), period});
    write_reg(REG_WINDOW_TICKS, window);
    write_reg(REG_SPEED_NUM, {8'($urandom()), num});
    write_reg(REG_SPEED_DIV, div);
    write_reg(REG_FAST_LEVEL, {8'($urandom()), fast});
    write_reg(REG_SLOW_LEVEL, {8'($urandom()), slow});
    settings_used++;
  endtask

  // Idle means no tick queued or on offer and every result collected.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || offering || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, a directed part over three settings, then random
  // phases, each with fresh register values, until the tick budget is used.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  period;
    logic [15:0] window;
    logic [15:0] div;
    int          r;
    int          n;
    int          pct_a;
    int          pct_b;
    int          pct_cmd;

    predictor_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset values: every command, a command byte with its valid low,
    // and command bytes that mean nothing.
    settings_used = 1;
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, CMD_FWD));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, CMD_FAST));
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, CMD_REV));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, CMD_LEFT));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, CMD_RIGHT));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b0, CMD_FWD));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, CMD_STOP));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, UNKNOWN_LOW));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, UNKNOWN_HIGH));
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, CMD_SLOW));
    wait_idle();

    // Writes to indexes beyond the register list must not land anywhere.
    write_reg(REG_SPARE_LO, 16'($urandom()));
    write_reg(REG_SPARE_HI, 16'($urandom()));

    // Slow level zero keeps the bridges off; a duty above the period keeps
    // PWM high; window and divisor of zero act as one, so every tick updates.
    program_registers(8'd3, 16'd0, 8'd255, 16'd0, 8'd255, 8'd0);
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, CMD_SLOW));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, CMD_FWD));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, CMD_FAST));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, CMD_RIGHT));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b0, UNKNOWN_LOW));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, UNKNOWN_HIGH));
    wait_idle();

    // Period one and the widest window and divisor; the period drops below
    // the running tick count, and level commands leave the duties alone.
    program_registers(8'd1, 16'd65535, 8'd1, 16'd65535, 8'd1, 8'd255);
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, CMD_FAST));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, CMD_REV));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, CMD_SLOW));
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, CMD_LEFT));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, CMD_STOP));
    wait_idle();

    // Random phases. Short periods and windows dominate so that wraps and
    // speed updates are frequent; windows of a few hundred ticks with full
    // pulse density drive the speed into saturation.
    while (ticks_queued < TARGET_TICKS) begin
      r = $urandom_range(0, 9);
      if (r == 0) period = 8'd0;
      else if (r == 1) period = 8'd255;
      else if (r < 6) period = 8'($urandom_range(1, 16));
      else period = 8'($urandom_range(1, 255));

      r = $urandom_range(0, 19);
      if (r == 0) window = 16'd0;
      else if (r == 1) window = 16'd65535;
      else if (r < 4) window = 16'd1;
      else if (r < 8) window = 16'($urandom_range(250, 400));
      else window = 16'($urandom_range(2, 40));

      r = $urandom_range(0, 9);
      if (r == 0) div = 16'd0;
      else if (r == 1) div = 16'd1;
      else if (r == 2) div = 16'd65535;
      else div = 16'($urandom_range(1, 2000));

      program_registers(period, window, pick_byte_setting(), div,
                        pick_byte_setting(), pick_byte_setting());
      pct_a   = pick_density();
      pct_b   = pick_density();
      pct_cmd = $urandom_range(5, 60);
      n       = $urandom_range(60, 180);
      repeat (n) queue_tick(random_tick(pct_a, pct_b, pct_cmd));
      // While this phase's ticks are on offer, the receiver stops for a while.
      if (settings_used == HOLD_PHASE) long_hold_req = 1'b1;
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());

    $display("Run covered %0d ticks under %0d register settings, %0d speed updates.",
             ticks_taken, settings_used, updates_seen);
    $display("Checked %0d results, %0d field mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d ticks still queued and %0d results outstanding.",
             pending_ticks.size(), expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
